[rtl/core/tmm_pkg.sv]
`default_nettype none

package tmm_pkg;

    localparam int unsigned DIM      = 8;
    localparam int unsigned IDX_W    = $clog2(DIM);
    localparam int unsigned ADDR_W   = 2 * IDX_W;
    localparam int unsigned DEPTH    = DIM * DIM;
    localparam int unsigned ELEM_W   = 32;
    localparam int unsigned ACC_W    = 64;
    localparam int unsigned SPAN_W   = 5;
    localparam int unsigned TILE_MAX = 8;

    localparam logic [SPAN_W-1:0] DIM_LIM  = SPAN_W'(DIM > 16 ? 16 : DIM);
    localparam logic [3:0]        TILE_LIM = 4'(TILE_MAX);
    localparam logic [IDX_W-1:0]  K_LAST   = IDX_W'(DIM - 1);

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_ROW_START = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_COL_START = 2'd2;
    localparam logic [1:0] CFG_COLS      = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // Clipped end of a tile span: start plus length (at most TILE_MAX), capped at DIM.
    function automatic logic [SPAN_W-1:0] span_end(input logic [IDX_W-1:0] start,
                                                   input logic [3:0] len);
        logic [3:0]        n;
        logic [SPAN_W-1:0] e;
        n = (len > TILE_LIM) ? TILE_LIM : len;
        e = SPAN_W'(start) + SPAN_W'(n);
        return (e > DIM_LIM) ? DIM_LIM : e;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tmm_ram.sv]
`default_nettype none

module tmm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/tmm_mac.sv]
`default_nettype none

module tmm_mac (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tmm_pkg::mac_ctl_t                issue,
    input  wire logic signed [tmm_pkg::ELEM_W-1:0] a_data,
    input  wire logic signed [tmm_pkg::ELEM_W-1:0] b_data,
    output logic                                  done,
    output logic signed [tmm_pkg::ACC_W-1:0]      acc
);
    import tmm_pkg::*;

    mac_ctl_t                ctl_s1_reg;
    mac_ctl_t                ctl_s2_reg;
    logic signed [ACC_W-1:0] product_reg;
    logic signed [ACC_W-1:0] product_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] acc_base;
    logic        [ACC_W:0]   sum;
    logic                    done_reg;

    assign product_next = ACC_W'(a_data) * ACC_W'(b_data);

    // Saturate when the carry out disagrees with the sign bit.
    always_comb
    begin
        acc_base = ctl_s2_reg.first ? '0 : acc_reg;
        sum      = {product_reg[ACC_W-1], product_reg} + {acc_base[ACC_W-1], acc_base};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s1_reg <= '0;
            ctl_s2_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ctl_s1_reg <= issue;
            ctl_s2_reg <= ctl_s1_reg;
            done_reg   <= ctl_s2_reg.valid && ctl_s2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        if (ctl_s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

[rtl/core/tiled_matrix_multiply.sv]
// Load transaction: one per cycle while idle, written to the element memory at the accept edge.
// Compute transaction: the first result comes from DIM reads of the A and B memories, a multiply
// stage, an accumulate stage and the output capture; each further result repeats these steps,
// and its first read waits for the output register to empty. No input is taken until the last
// result is captured.
// Reset clears control and the tile registers (start 0, size 8); memories are not cleared.
`default_nettype none

module tiled_matrix_multiply (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          cmd,
    input  wire logic [2:0]          row_index,
    input  wire logic [2:0]          col_index,
    input  wire logic signed [31:0]  element_value,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [2:0]               result_row,
    output logic [2:0]               result_col,
    output logic signed [63:0]       result_value,
    output logic                     last,
    input  wire logic                cfg_write_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [3:0]          cfg_data
);
    import tmm_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [2:0] row_start_reg;
    logic [3:0] rows_reg;
    logic [2:0] col_start_reg;
    logic [3:0] cols_reg;

    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [SPAN_W-1:0] re_reg;
    logic [SPAN_W-1:0] ce_reg;

    logic              out_valid_reg;
    logic [2:0]        result_row_reg;
    logic [2:0]        result_col_reg;
    logic [ACC_W-1:0]  result_value_reg;
    logic              last_reg;

    logic              in_accept;
    logic              out_accept;
    logic              compute_go;
    logic              issue_en;
    logic              row_last;
    logic              col_last;
    logic              tile_last;
    logic [SPAN_W-1:0] re_calc;
    logic [SPAN_W-1:0] ce_calc;
    logic              tile_empty;
    logic              load_in_range;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;
    logic [ELEM_W-1:0] a_rdata;
    logic [ELEM_W-1:0] b_rdata;
    mac_ctl_t          mac_issue;
    logic              mac_done;
    logic [ACC_W-1:0]  mac_acc;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    assign re_calc    = span_end(row_start_reg, rows_reg);
    assign ce_calc    = span_end(col_start_reg, cols_reg);
    assign tile_empty = (SPAN_W'(row_start_reg) >= re_calc) || (SPAN_W'(col_start_reg) >= ce_calc);
    assign compute_go = in_accept && (cmd == CMD_COMPUTE) && !tile_empty;

    assign load_in_range = (32'(row_index) < DIM) && (32'(col_index) < DIM);
    assign load_addr     = {row_index[IDX_W-1:0], col_index[IDX_W-1:0]};

    assign row_last  = (SPAN_W'(i_reg) + SPAN_W'(1)) == re_reg;
    assign col_last  = (SPAN_W'(j_reg) + SPAN_W'(1)) == ce_reg;
    assign tile_last = row_last && col_last;

    assign a_raddr = {i_reg, k_reg};
    assign b_raddr = {k_reg, j_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (compute_go)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (issue_en && (k_reg == K_LAST))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = tile_last ? ST_IDLE : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer; hold the first read of a result until the output is free
    always_comb
    begin
        in_stall = 1'b1;
        issue_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_ISSUE:
            begin
                issue_en = (k_reg != '0) || !out_valid_reg;
            end
            ST_WAIT:
            begin
                issue_en = 1'b0;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign mac_issue.valid = issue_en;
    assign mac_issue.first = (k_reg == '0);
    assign mac_issue.last  = (k_reg == K_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_start_reg <= 3'd0;
            rows_reg      <= 4'd8;
            col_start_reg <= 3'd0;
            cols_reg      <= 4'd8;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            re_reg        <= '0;
            ce_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_ROW_START: row_start_reg <= cfg_data[2:0];
                    CFG_ROWS:      rows_reg      <= cfg_data;
                    CFG_COL_START: col_start_reg <= cfg_data[2:0];
                    CFG_COLS:      cols_reg      <= cfg_data;
                    default:       rows_reg      <= rows_reg;
                endcase
            end

            if (compute_go)
            begin
                i_reg  <= IDX_W'(row_start_reg);
                j_reg  <= IDX_W'(col_start_reg);
                k_reg  <= '0;
                re_reg <= re_calc;
                ce_reg <= ce_calc;
            end
            else if (issue_en)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
            else if ((state_reg == ST_WAIT) && mac_done && !tile_last)
            begin
                // Advance to the next result: along the row, then wrap to the next row
                k_reg <= '0;
                if (col_last)
                begin
                    j_reg <= IDX_W'(col_start_reg);
                    i_reg <= i_reg + IDX_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end

            if (mac_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_done)
        begin
            result_row_reg   <= 3'(i_reg);
            result_col_reg   <= 3'(j_reg);
            result_value_reg <= mac_acc;
            last_reg         <= tile_last;
        end
    end

    tmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_mem (
        .clk   (clk),
        .we    (in_accept && (cmd == CMD_LOAD_A) && load_in_range),
        .waddr (load_addr),
        .wdata (element_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    tmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_mem (
        .clk   (clk),
        .we    (in_accept && (cmd == CMD_LOAD_B) && load_in_range),
        .waddr (load_addr),
        .wdata (element_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    tmm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (mac_issue),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .done   (mac_done),
        .acc    (mac_acc)
    );

    assign out_valid    = out_valid_reg;
    assign result_row   = result_row_reg;
    assign result_col   = result_col_reg;
    assign result_value = result_value_reg;
    assign last         = last_reg;

    // A finished dot product never lands on an unread result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> !out_valid_reg)
        else $error("result captured while output register full");

    // Results only finish while waiting on the pipeline
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_WAIT))
        else $error("dot product finished outside wait state");

    // A new output transaction comes only from a finished dot product
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(mac_done))
        else $error("output valid without a finished result");

    // No input is taken while a tile is in progress
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_accept)
        else $error("input accepted during compute");

endmodule

`default_nettype wire
